>>> rtl/mep_pkg.sv
// Package for the Mandelbrot escape-time pixel block.
// Holds the shared constants, register codes and the Q4.28 saturation helper.
// No dependencies.
package mep_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;
  localparam int HALF_WIDTH    = SCREEN_WIDTH / 2;
  localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

  localparam int PIX_W   = 10;
  localparam int OFF_W   = 14;   // signed pixel offset, holds -8192..8191
  localparam int Q_W     = 32;
  localparam int PROD_W  = 2 * Q_W;
  localparam int Q_FRAC  = 28;
  localparam int ITER_W  = 12;
  localparam int CH_W    = 8;
  localparam int COLOR_W = 24;
  localparam int SCALE_W = 31;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DIV_NUM_W  = ITER_W + CH_W;
  localparam int DIV_STEP_W = 3;

  localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_IM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE_COLOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_COLOR = 3'd6;

  localparam logic [SCALE_W-1:0] RST_SCALE_RE      = 31'd2621440;
  localparam logic [SCALE_W-1:0] RST_SCALE_IM      = 31'd2097152;
  localparam logic [ITER_W-1:0]  RST_MAX_ITER      = 12'd64;
  localparam logic [COLOR_W-1:0] RST_INSIDE_COLOR  = 24'h000000;
  localparam logic [COLOR_W-1:0] RST_OUTSIDE_COLOR = 24'hFFFFFF;

  localparam logic signed [PROD_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/mandelbrot_escape_pixel_top.sv
// Mandelbrot escape-time pixel evaluator, top level.
// Holds the sequencer, the configuration registers and the output register.
// Depends on mep_pkg, mep_mul and mep_div.
//
// Usage:
//   s_axis carries one pixel per transfer: tdata = pixel_x, pixel_y (24 bits).
//   m_axis returns one result per pixel: tdata = out_x, out_y, iterations,
//   red, green, blue (56 bits).
//   cfg_we/cfg_index/cfg_data write the seven registers; write only while idle.
// Sequence:
//   One pixel at a time. Mapping runs through S_IDLE, S_MAPY and S_MAPC, then
//   S_RI; each iteration runs through S_UPD, S_SQR, S_SQI and S_MAG on the single
//   shared multiplier, an escaped pixel adds the red scaling (multiply plus
//   8-step divider), and S_FIN loads the output register.
//   s_axis_tready is high only between pixels.
// Reset: synchronous rst returns registers to defaults and empties the output.
// Stall: a finished result waits in the output register; the next pixel can
//   be taken meanwhile, and its result waits inside until the register frees.
module mandelbrot_escape_pixel_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mep_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // pixel_x, pixel_y, pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mep_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // out_x, out_y, iterations,
                                                           // red, green, blue
  input  logic                              cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mep_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MAPY = 12'b0000_0000_0010,
    S_MAPC = 12'b0000_0000_0100,
    S_RI   = 12'b0000_0000_1000,
    S_UPD  = 12'b0000_0001_0000,
    S_SQR  = 12'b0000_0010_0000,
    S_SQI  = 12'b0000_0100_0000,
    S_MAG  = 12'b0000_1000_0000,
    S_CMUL = 12'b0001_0000_0000,
    S_DIV  = 12'b0010_0000_0000,
    S_WAIT = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SCALE_W-1:0]        scale_re;
  logic [SCALE_W-1:0]        scale_im;
  logic signed [Q_W-1:0]     center_re;
  logic signed [Q_W-1:0]     center_im;
  logic [ITER_W-1:0]         max_iter;
  logic [COLOR_W-1:0]        inside_color;
  logic [COLOR_W-1:0]        outside_color;

  logic [PIX_W-1:0]          px;
  logic [PIX_W-1:0]          py;
  logic signed [Q_W-1:0]     cr;
  logic signed [Q_W-1:0]     ci;
  logic signed [Q_W-1:0]     zr;
  logic signed [Q_W-1:0]     zi;
  logic signed [PROD_W-1:0]  rr;
  logic signed [PROD_W-1:0]  ii;
  logic [ITER_W-1:0]         count;

  logic signed [Q_W-1:0]     mul_a;
  logic signed [Q_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic [OFF_W-1:0]          off_x;
  logic [OFF_W-1:0]          off_y;
  logic signed [PROD_W-1:0]  map_sum;
  logic signed [PROD_W-1:0]  nr_wide;
  logic signed [PROD_W-1:0]  ni_wide;
  logic [PROD_W-1:0]         mag;
  logic                      escape;
  logic [ITER_W:0]           count_inc;
  logic                      in_xfer;
  logic                      out_free;
  logic                      bounded;
  logic                      div_done;
  logic [CH_W-1:0]           div_quo;
  logic [CH_W-1:0]           red_v;
  logic [CH_W-1:0]           green_v;
  logic [CH_W-1:0]           blue_v;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign off_x = OFF_W'(s_axis_tdata[PIX_W-1:0]) - OFF_W'(HALF_WIDTH);
  assign off_y = OFF_W'(py) - OFF_W'(HALF_HEIGHT);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: begin
        mul_a = {{(Q_W-OFF_W){off_x[OFF_W-1]}}, off_x};
        mul_b = {1'b0, scale_re};
      end
      S_MAPY: begin
        mul_a = {{(Q_W-OFF_W){off_y[OFF_W-1]}}, off_y};
        mul_b = {1'b0, scale_im};
      end
      S_RI, S_MAG: begin
        mul_a = zr;
        mul_b = zi;
      end
      S_SQR: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_SQI: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_CMUL: begin
        mul_a = {{(Q_W-ITER_W){1'b0}}, count};
        mul_b = {{(Q_W-CH_W){1'b0}}, outside_color[COLOR_W-1 -: CH_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  mep_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV),
    .num   (mul_p[DIV_NUM_W-1:0]),
    .den   (max_iter),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign map_sum   = mul_p + PROD_W'(state == S_MAPY ? center_re : center_im);
  assign nr_wide   = ((rr - ii) >>> Q_FRAC) + PROD_W'(cr);
  assign ni_wide   = (mul_p >>> (Q_FRAC - 1)) + PROD_W'(ci);
  assign mag       = $unsigned(rr) + $unsigned(mul_p);
  assign escape    = (mag > ESCAPE_LIMIT);
  assign count_inc = {1'b0, count} + 1'b1;
  assign bounded   = (count == max_iter);

  assign red_v   = bounded ? inside_color[23:16] : div_quo;
  assign green_v = bounded ? inside_color[15:8]  : outside_color[15:8];
  assign blue_v  = bounded ? inside_color[7:0]   : outside_color[7:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_MAPY;
        end
      end
      S_MAPY: state_next = S_MAPC;
      S_MAPC: state_next = (max_iter == '0) ? S_FIN : S_RI;
      S_RI:   state_next = S_UPD;
      S_UPD:  state_next = S_SQR;
      S_SQR:  state_next = S_SQI;
      S_SQI:  state_next = S_MAG;
      S_MAG: begin
        if (escape) begin
          state_next = S_CMUL;
        end else if (count_inc == {1'b0, max_iter}) begin
          state_next = S_FIN;
        end else begin
          state_next = S_UPD;
        end
      end
      S_CMUL: state_next = S_DIV;
      S_DIV:  state_next = S_WAIT;
      S_WAIT: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px <= s_axis_tdata[PIX_W-1:0];
      py <= s_axis_tdata[2*PIX_W-1:PIX_W];
    end
    if (state == S_MAPY) begin
      cr <= sat32(map_sum);
    end
    if (state == S_MAPC) begin
      ci    <= sat32(map_sum);
      zr    <= '0;
      zi    <= '0;
      rr    <= '0;
      ii    <= '0;
      count <= '0;
    end
    if (state == S_UPD) begin
      zr <= sat32(nr_wide);
      zi <= sat32(ni_wide);
    end
    if (state == S_SQI) begin
      rr <= mul_p;
    end
    if (state == S_MAG) begin
      ii <= mul_p;
      if (!escape) begin
        count <= count_inc[ITER_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_axis_tdata <= {blue_v, green_v, red_v, count, py, px};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_re      <= RST_SCALE_RE;
      scale_im      <= RST_SCALE_IM;
      center_re     <= '0;
      center_im     <= '0;
      max_iter      <= RST_MAX_ITER;
      inside_color  <= RST_INSIDE_COLOR;
      outside_color <= RST_OUTSIDE_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_RE:      scale_re      <= cfg_data[SCALE_W-1:0];
        REG_SCALE_IM:      scale_im      <= cfg_data[SCALE_W-1:0];
        REG_CENTER_RE:     center_re     <= cfg_data;
        REG_CENTER_IM:     center_im     <= cfg_data;
        REG_MAX_ITER:      max_iter      <= cfg_data[ITER_W-1:0];
        REG_INSIDE_COLOR:  inside_color  <= cfg_data[COLOR_W-1:0];
        REG_OUTSIDE_COLOR: outside_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mep_mul.sv
// Shared 32x32 signed multiplier with a registered product.
// Used for pixel mapping, every z square/cross term and the red scaling.
// Depends on mep_pkg.
module mep_mul (
  input  logic                              clk,
  input  logic signed [mep_pkg::Q_W-1:0]    a,
  input  logic signed [mep_pkg::Q_W-1:0]    b,
  output logic signed [mep_pkg::PROD_W-1:0] p
);
  import mep_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> rtl/mep_div.sv
// Restoring divider, one quotient bit per cycle, for the red channel scaling.
// The quotient is known to fit in eight bits (numerator < 256 * denominator).
// Depends on mep_pkg.
module mep_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mep_pkg::DIV_NUM_W-1:0]    num,
  input  logic [mep_pkg::ITER_W-1:0]       den,
  output logic                             done,
  output logic [mep_pkg::CH_W-1:0]         quo
);
  import mep_pkg::*;

  logic [DIV_NUM_W-1:0]  rem;
  logic [DIV_NUM_W-1:0]  dsh;
  logic [DIV_STEP_W-1:0] step;
  logic                  busy;
  logic                  fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && step == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {1'b0, den, {(CH_W-1){1'b0}}};
      step <= DIV_STEP_W'(CH_W - 1);
      quo  <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo  <= {quo[CH_W-2:0], fits};
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

endmodule

>>> rtl/mep_checker.sv
// Port-level checks for the Mandelbrot escape-time pixel block.
// Bound to mandelbrot_escape_pixel_top; depends on mep_pkg for port widths.
module mep_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mep_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

  // an accepted pixel keeps the input side closed through mapping and on to S_FIN
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while a pixel is in progress");

  // a new result shows up together with the return to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result presented while still busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_mandelbrot_escape_pixel_top.sv
// Testbench for the Mandelbrot escape-time pixel block: directed and random pixels
// under several views, checked against a Q4.28 escape-time predictor kept in step here.
// Depends on mep_pkg and mandelbrot_escape_pixel_top.
`timescale 1ns / 100ps

module tb_mandelbrot_escape_pixel_top;
  import mep_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int END_PAUSE = 64;
  localparam int ONE_Q = 268435456;  // 1.0 in Q4.28
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint Q_MAX = (64'sd1 <<< 31) - 1;
  localparam longint Q_MIN = -(64'sd1 <<< 31);

  // matches m_axis_tdata, out_x in the lowest bits
  typedef struct packed {
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   red;
    logic [ITER_W-1:0] iterations;
    logic [PIX_W-1:0]  out_y;
    logic [PIX_W-1:0]  out_x;
  } escape_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // pixel_x, pixel_y, pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // out_x, out_y, iterations, red, green, blue
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow
  logic [SCALE_W-1:0]   cfg_scale_re = RST_SCALE_RE;
  logic [SCALE_W-1:0]   cfg_scale_im = RST_SCALE_IM;
  logic signed [Q_W-1:0] cfg_center_re = '0;
  logic signed [Q_W-1:0] cfg_center_im = '0;
  logic [ITER_W-1:0]    cfg_max_iter = RST_MAX_ITER;
  logic [COLOR_W-1:0]   cfg_inside_color = RST_INSIDE_COLOR;
  logic [COLOR_W-1:0]   cfg_outside_color = RST_OUTSIDE_COLOR;

  escape_result_t expected_escapes[$];
  int  mismatches = 0;
  int  burst_left = 0;
  int  stall_left = 0;
  int  stuck_cycles = 0;
  bit  tx_gaps = 1'b0;
  bit  rx_stalls = 1'b0;

  mandelbrot_escape_pixel_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end else if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  function automatic escape_result_t escape_pixel(input logic [PIX_W-1:0] px,
                                                  input logic [PIX_W-1:0] py);
    escape_result_t res;
    longint c_re, c_im, z_re, z_im, next_re, next_im;
    logic [PROD_W-1:0] mag;
    int unsigned count;
    logic [COLOR_W-1:0] color;
    c_re = clamp_q428((longint'(px) - HALF_WIDTH) * longint'(cfg_scale_re) +
                      longint'(cfg_center_re));
    c_im = clamp_q428((longint'(py) - HALF_HEIGHT) * longint'(cfg_scale_im) +
                      longint'(cfg_center_im));
    z_re = 0;
    z_im = 0;
    count = 0;
    while (count < cfg_max_iter) begin
      next_re = clamp_q428(((z_re * z_re - z_im * z_im) >>> Q_FRAC) + c_re);
      next_im = clamp_q428(((z_re * z_im) >>> (Q_FRAC - 1)) + c_im);
      z_re = next_re;
      z_im = next_im;
      mag = z_re * z_re + z_im * z_im;
      if (mag > ESCAPE_LIMIT) break;
      count++;
    end
    if (count == cfg_max_iter) begin
      color = cfg_inside_color;
    end else begin
      color = {CH_W'((count * cfg_outside_color[23:16]) / cfg_max_iter),
               cfg_outside_color[15:0]};
    end
    res.out_x = px;
    res.out_y = py;
    res.iterations = ITER_W'(count);
    res.red = color[23:16];
    res.green = color[15:8];
    res.blue = color[7:0];
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCALE_RE:      cfg_scale_re = value[SCALE_W-1:0];
      REG_SCALE_IM:      cfg_scale_im = value[SCALE_W-1:0];
      REG_CENTER_RE:     cfg_center_re = value;
      REG_CENTER_IM:     cfg_center_im = value;
      REG_MAX_ITER:      cfg_max_iter = value[ITER_W-1:0];
      REG_INSIDE_COLOR:  cfg_inside_color = value[COLOR_W-1:0];
      REG_OUTSIDE_COLOR: cfg_outside_color = value[COLOR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_view(input logic [31:0] scale_re, input logic [31:0] scale_im,
                          input logic [31:0] center_re, input logic [31:0] center_im,
                          input logic [31:0] max_iter, input logic [31:0] inside_color,
                          input logic [31:0] outside_color);
    write_reg(REG_SCALE_RE, scale_re);
    write_reg(REG_SCALE_IM, scale_im);
    write_reg(REG_CENTER_RE, center_re);
    write_reg(REG_CENTER_IM, center_im);
    write_reg(REG_MAX_ITER, max_iter);
    write_reg(REG_INSIDE_COLOR, inside_color);
    write_reg(REG_OUTSIDE_COLOR, outside_color);
  endtask

  // valid stays high after a transfer; only a gap or drain() lowers it
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, py, px};
    do @(posedge clk); while (!s_axis_tready);
    expected_escapes.push_back(escape_pixel(px, py));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
  endtask

  task automatic pick_idling();
    tx_gaps = ($urandom_range(0, 3) != 0);
    rx_stalls = ($urandom_range(0, 3) != 0);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    escape_result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = escape_result_t'(m_axis_tdata);
      if (expected_escapes.size() == 0) begin
        $error("result with no pixel pending: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_escapes.pop_front();
        check_field("out_x", 32'(want.out_x), 32'(got.out_x));
        check_field("out_y", 32'(want.out_y), 32'(got.out_y));
        check_field("iterations", 32'(want.iterations), 32'(got.iterations));
        check_field("red", 32'(want.red), 32'(got.red));
        check_field("green", 32'(want.green), 32'(got.green));
        check_field("blue", 32'(want.blue), 32'(got.blue));
      end
    end
  end

  always @(posedge clk) begin
    if (!rx_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 24);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // reset values, screen corners and the view center
  task automatic test_default_view();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd256, 10'd600);
    drain();
  endtask

  // |z|^2 landing exactly on 4 must not count as escaped
  task automatic test_escape_boundary();
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    set_view(32'd0, 32'd0, 32'(2 * ONE_Q), 32'd0, 32'd64, 32'h00A0_B0C0, 32'h00FF_8040);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    drain();
    write_reg(REG_CENTER_RE, 32'(-2 * ONE_Q));
    send_pixel(10'd7, 10'd900);
    drain();
    write_reg(REG_CENTER_RE, 32'd0);
    write_reg(REG_CENTER_IM, 32'(2 * ONE_Q));
    send_pixel(10'd300, 10'd300);
    drain();
  endtask

  // largest scales and centers, upper register bits set
  task automatic test_saturation();
    rx_stalls = 1'b1;
    set_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_FFFF, 32'hFF12_3456, 32'hFFFF_FFFF);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd511, 10'd513);
    drain();
    set_view(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0040, 32'h0000_0000, 32'h0000_0000);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    drain();
  endtask

  // a zero limit gives the inside color without iterating; a limit of one iterates once
  task automatic test_small_limits();
    set_view(32'(RST_SCALE_RE), 32'(RST_SCALE_IM), 32'd0, 32'd0,
             32'hABCD_E000, 32'h0055_AA55, 32'h00C0_FFEE);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd200);
    drain();
    write_reg(REG_MAX_ITER, 32'd1);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    drain();
  endtask

  // full iteration limit, points inside and outside
  task automatic test_long_limit();
    tx_gaps = 1'b1;
    set_view(32'(RST_SCALE_RE), 32'(RST_SCALE_IM), 32'd0, 32'd0,
             32'd4095, $urandom, $urandom);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd400, 10'd512);
    send_pixel(10'd0, 10'd512);
    drain();
  endtask

  task automatic test_random_full_view();
    pick_idling();
    set_view(32'(RST_SCALE_RE), 32'(RST_SCALE_IM), 32'd0, 32'd0,
             32'd64, $urandom, $urandom);
    send_random_pixels(100);
    drain();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_random_pixels(100);
    drain();
  endtask

  // zoomed views near the set boundary
  task automatic test_random_zoomed();
    repeat (4) begin
      pick_idling();
      set_view($urandom_range(1, 1 << 18), $urandom_range(1, 1 << 18),
               32'($urandom_range(0, 5 * ONE_Q / 2) - 2 * ONE_Q),
               32'($urandom_range(0, 2 * ONE_Q) - ONE_Q),
               $urandom_range(32, 256), $urandom, $urandom);
      send_random_pixels(40);
      drain();
    end
  endtask

  task automatic test_random_short_limit();
    repeat (5) begin
      pick_idling();
      set_view($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22),
               32'($urandom_range(0, 4 * ONE_Q) - 2 * ONE_Q),
               32'($urandom_range(0, 4 * ONE_Q) - 2 * ONE_Q),
               $urandom_range(1, 12), $urandom, $urandom);
      send_random_pixels(40);
      drain();
    end
  endtask

  // any register value, limit kept low so runs stay short
  task automatic test_random_wild();
    logic [31:0] limit;
    repeat (4) begin
      pick_idling();
      limit = $urandom;
      limit[ITER_W-1:0] = ITER_W'($urandom_range(0, 40));
      set_view($urandom, $urandom, $urandom, $urandom, limit, $urandom, $urandom);
      send_random_pixels(30);
      drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_view();
    test_escape_boundary();
    test_saturation();
    test_small_limits();
    test_long_limit();
    test_random_full_view();
    test_random_zoomed();
    test_random_short_limit();
    test_random_wild();
    drain();
    repeat (END_PAUSE) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
